// ===== sv/pisl_pkg.sv =====
// Shared constants, register map and helpers for the PI speed loop.
package pisl_pkg;

    // Field widths
    localparam int CMD_W    = 7;
    localparam int RPM_W    = 24;
    localparam int TGT_W    = 23;
    localparam int GAIN_W   = 16;
    localparam int LIM_W    = 15;
    localparam int PWM_W    = 7;
    localparam int ACC_W    = 32;
    localparam int ERR_W    = 25;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LOW    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH   = 3'd6;

    // Reset values
    localparam logic [GAIN_W-1:0] RST_SPEED_GAIN = 16'd640;
    localparam logic [GAIN_W-1:0] RST_PROP_GAIN  = 16'd128;
    localparam logic [GAIN_W-1:0] RST_INTEG_GAIN = 16'd51;
    localparam logic [GAIN_W-1:0] RST_STEP_TIME  = 16'd655;
    localparam logic [GAIN_W-1:0] RST_DEADBAND   = 16'd3;
    localparam logic [LIM_W-1:0]  RST_OUT_LOW    = 15'd0;
    localparam logic [LIM_W-1:0]  RST_OUT_HIGH   = 15'd25600;

    // Saturate a 33-bit signed sum to the 32-bit integrator range
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
        logic signed [ACC_W-1:0] res;
        begin
            if (v[ACC_W] != v[ACC_W-1]) begin
                res = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
            end else begin
                res = v[ACC_W-1:0];
            end
            return res;
        end
    endfunction

endpackage

// ===== sv/pi_speed_loop_antiwindup.sv =====
// PI speed loop with deadband and anti-windup clamp, one shared multiplier.
// An accepted input beat passes through states TGT, ERR, STEP, ACC, INTEG, PI and OUT,
// where it waits for the output to be free; the single 33x17 multiplier is used four
// times per item in sequence, and the input is stalled until the item is done.
// Reset (synchronous, active low): configuration registers return to their defaults,
// the integrator clears to zero, the sequencer idles and the output is empty.
module pi_speed_loop_antiwindup
    import pisl_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write port
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DAT_W-1:0]    i_cfg_wdata,
    // input channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [CMD_W-1:0]        i_command_pct,
    input  logic signed [RPM_W-1:0] i_measured_rpm,
    // output channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [LIM_W-1:0]        o_correction,
    output logic [PWM_W-1:0]        o_final_pwm,
    output logic [TGT_W-1:0]        o_target_rpm,
    output logic                    o_clamped
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TGT   = 3'd1;
    localparam logic [2:0] ST_ERR   = 3'd2;
    localparam logic [2:0] ST_STEP  = 3'd3;
    localparam logic [2:0] ST_ACC   = 3'd4;
    localparam logic [2:0] ST_INTEG = 3'd5;
    localparam logic [2:0] ST_PI    = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    localparam logic signed [PROD_W-1:0] TARGET_MAX = PROD_W'(8388607);

    logic [2:0] r_state, n_state;

    // configuration registers
    logic [GAIN_W-1:0] r_speed_gain, r_prop_gain, r_integ_gain, r_step_time, r_deadband;
    logic [LIM_W-1:0]  r_out_low, r_out_high;

    // item registers
    logic [CMD_W-1:0]         r_cmd;
    logic signed [RPM_W-1:0]  r_meas;
    logic [TGT_W-1:0]         r_target;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [ERR_W-1:0]  r_step;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_pp;
    logic [LIM_W-1:0]         r_corr;
    logic                     r_hit;
    logic signed [ACC_W-1:0]  r_integ;

    // output registers
    logic             r_out_valid;
    logic [LIM_W-1:0] r_out_corr;
    logic [PWM_W-1:0] r_out_pwm;
    logic [TGT_W-1:0] r_out_tgt;
    logic             r_out_hit;

    logic in_take;
    logic out_free;

    assign in_take  = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // Shared multiplier operand select
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;

    always_comb begin
        unique case (r_state)
            ST_TGT: begin
                w_mul_a = $signed({{(MUL_A_W-CMD_W){1'b0}}, r_cmd});
                w_mul_b = $signed({1'b0, r_speed_gain});
            end
            ST_STEP: begin
                w_mul_a = {{(MUL_A_W-ERR_W){r_err[ERR_W-1]}}, r_err};
                w_mul_b = $signed({1'b0, r_step_time});
            end
            ST_ACC: begin
                w_mul_a = {{(MUL_A_W-ERR_W){r_err[ERR_W-1]}}, r_err};
                w_mul_b = $signed({1'b0, r_prop_gain});
            end
            ST_INTEG: begin
                w_mul_a = {r_integ[ACC_W-1], r_integ};
                w_mul_b = $signed({1'b0, r_integ_gain});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // Target saturation and speed error
    logic [TGT_W-1:0]        w_target;
    logic signed [ERR_W-1:0] w_err;

    assign w_target = (r_prod > TARGET_MAX) ? {TGT_W{1'b1}} : r_prod[TGT_W-1:0];
    assign w_err    = $signed({2'b00, w_target}) - $signed({r_meas[RPM_W-1], r_meas});

    // Integral step (floor of err * step_time / 2^16) and deadband test
    logic signed [ERR_W-1:0] w_step;
    logic [ERR_W-1:0]        w_mag;
    logic                    w_in_band;
    logic signed [ACC_W:0]   w_acc_add;
    logic signed [ACC_W:0]   w_acc_sub;

    assign w_step    = r_prod[ERR_W+15:16];
    assign w_mag     = r_err[ERR_W-1] ? ERR_W'(-r_err) : ERR_W'(r_err);
    assign w_in_band = w_mag < {{(ERR_W-GAIN_W){1'b0}}, r_deadband};
    assign w_acc_add = {r_integ[ACC_W-1], r_integ}
                     + {{(ACC_W+1-ERR_W){w_step[ERR_W-1]}}, w_step};
    assign w_acc_sub = {r_integ[ACC_W-1], r_integ}
                     - {{(ACC_W+1-ERR_W){r_step[ERR_W-1]}}, r_step};

    // PI sum, floor divide by 2^8, clamp to limits (upper test first)
    localparam int PI_W = PROD_W - 8;
    logic signed [PROD_W-1:0] w_pi_sum;
    logic signed [PI_W-1:0]   w_pi;
    logic signed [PI_W-1:0]   w_hi_ext, w_lo_ext;
    logic [LIM_W-1:0]         w_corr;
    logic                     w_hit;

    assign w_pi_sum = r_pp + r_prod;
    assign w_pi     = w_pi_sum[PROD_W-1:8];
    assign w_hi_ext = $signed({{(PI_W-LIM_W){1'b0}}, r_out_high});
    assign w_lo_ext = $signed({{(PI_W-LIM_W){1'b0}}, r_out_low});

    always_comb begin
        priority if (w_pi > w_hi_ext) begin
            w_corr = r_out_high;
            w_hit  = 1'b1;
        end else if (w_pi < w_lo_ext) begin
            w_corr = r_out_low;
            w_hit  = 1'b1;
        end else begin
            w_corr = w_pi[LIM_W-1:0];
            w_hit  = 1'b0;
        end
    end

    // Command plus correction, clamped the same way, whole percent
    logic [LIM_W:0]   w_sum;
    logic [LIM_W-1:0] w_sum_clamp;

    assign w_sum = {1'b0, r_cmd, 8'b0} + {1'b0, r_corr};

    always_comb begin
        priority if (w_sum > {1'b0, r_out_high}) begin
            w_sum_clamp = r_out_high;
        end else if (w_sum < {1'b0, r_out_low}) begin
            w_sum_clamp = r_out_low;
        end else begin
            w_sum_clamp = w_sum[LIM_W-1:0];
        end
    end

    // Sequencer next state
    always_comb begin
        unique case (r_state)
            ST_IDLE:  n_state = in_take ? ST_TGT : ST_IDLE;
            ST_TGT:   n_state = ST_ERR;
            ST_ERR:   n_state = ST_STEP;
            ST_STEP:  n_state = ST_ACC;
            ST_ACC:   n_state = ST_INTEG;
            ST_INTEG: n_state = ST_PI;
            ST_PI:    n_state = ST_OUT;
            ST_OUT:   n_state = out_free ? ST_IDLE : ST_OUT;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control state, integrator and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_integ      <= '0;
            r_out_valid  <= 1'b0;
            r_speed_gain <= RST_SPEED_GAIN;
            r_prop_gain  <= RST_PROP_GAIN;
            r_integ_gain <= RST_INTEG_GAIN;
            r_step_time  <= RST_STEP_TIME;
            r_deadband   <= RST_DEADBAND;
            r_out_low    <= RST_OUT_LOW;
            r_out_high   <= RST_OUT_HIGH;
        end else begin
            r_state <= n_state;

            // integrator: step or clear, then undo on clamp
            if (r_state == ST_ACC) begin
                r_integ <= w_in_band ? '0 : sat_acc(w_acc_add);
            end else if (r_state == ST_OUT && out_free && r_hit) begin
                r_integ <= sat_acc(w_acc_sub);
            end

            // output beat handshake
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    REG_SPEED_GAIN: r_speed_gain <= i_cfg_wdata;
                    REG_PROP_GAIN:  r_prop_gain  <= i_cfg_wdata;
                    REG_INTEG_GAIN: r_integ_gain <= i_cfg_wdata;
                    REG_STEP_TIME:  r_step_time  <= i_cfg_wdata;
                    REG_DEADBAND:   r_deadband   <= i_cfg_wdata;
                    REG_OUT_LOW:    r_out_low    <= i_cfg_wdata[LIM_W-1:0];
                    REG_OUT_HIGH:   r_out_high   <= i_cfg_wdata[LIM_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (in_take) begin
            r_cmd  <= i_command_pct;
            r_meas <= i_measured_rpm;
        end
        if (r_state == ST_ERR) begin
            r_target <= w_target;
            r_err    <= w_err;
        end
        if (r_state == ST_ACC) begin
            r_step <= w_step;
        end
        if (r_state == ST_INTEG) begin
            r_pp <= r_prod;
        end
        if (r_state == ST_PI) begin
            r_corr <= w_corr;
            r_hit  <= w_hit;
        end
        if (r_state == ST_OUT && out_free) begin
            r_out_corr <= r_corr;
            r_out_pwm  <= w_sum_clamp[LIM_W-1:8];
            r_out_tgt  <= r_target;
            r_out_hit  <= r_hit;
        end
    end

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_correction = r_out_corr;
    assign o_final_pwm  = r_out_pwm;
    assign o_target_rpm = r_out_tgt;
    assign o_clamped    = r_out_hit;

endmodule

// ===== tb/sv/tb_pi_speed_loop_antiwindup.sv =====
// Self-checking testbench for the PI speed loop with anti-windup clamp.
module tb_pi_speed_loop_antiwindup
    import pisl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint TARGET_TOP = 64'sd8388607;
    localparam longint RPM_TOP    = 64'sd8388607;
    localparam longint RPM_BOTTOM = -64'sd8388608;
    localparam longint ACC_TOP    = 64'sd2147483647;
    localparam longint ACC_BOTTOM = -64'sd2147483648;
    // index past the end of the register map, writes must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int MAX_REPORTS = 10;

    // One expected output beat
    typedef struct packed {
        logic [LIM_W-1:0] correction;
        logic [PWM_W-1:0] final_pwm;
        logic [TGT_W-1:0] target_rpm;
        logic             clamped;
    } t_pwm_result;

    // One full register setting
    typedef struct {
        logic [GAIN_W-1:0] speed_gain;
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain;
        logic [GAIN_W-1:0] step_time;
        logic [GAIN_W-1:0] deadband;
        logic [LIM_W-1:0]  out_low;
        logic [LIM_W-1:0]  out_high;
    } t_loop_settings;

    // Loop predictor plus queue of expected output beats
    class t_speed_loop_scoreboard;
        logic [GAIN_W-1:0]       speed_gain = RST_SPEED_GAIN;
        logic [GAIN_W-1:0]       prop_gain  = RST_PROP_GAIN;
        logic [GAIN_W-1:0]       integ_gain = RST_INTEG_GAIN;
        logic [GAIN_W-1:0]       step_time  = RST_STEP_TIME;
        logic [GAIN_W-1:0]       deadband   = RST_DEADBAND;
        logic [LIM_W-1:0]        out_low    = RST_OUT_LOW;
        logic [LIM_W-1:0]        out_high   = RST_OUT_HIGH;
        logic signed [ACC_W-1:0] integ_acc  = '0;
        t_pwm_result             pending_pwm_q[$];
        int                      mismatches = 0;
        int                      beats_checked = 0;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                REG_SPEED_GAIN: speed_gain = data;
                REG_PROP_GAIN:  prop_gain  = data;
                REG_INTEG_GAIN: integ_gain = data;
                REG_STEP_TIME:  step_time  = data;
                REG_DEADBAND:   deadband   = data;
                REG_OUT_LOW:    out_low    = data[LIM_W-1:0];
                REG_OUT_HIGH:   out_high   = data[LIM_W-1:0];
                default: ;
            endcase
        endfunction

        function longint sat_integ(longint v);
            if (v > ACC_TOP) return ACC_TOP;
            if (v < ACC_BOTTOM) return ACC_BOTTOM;
            return v;
        endfunction

        // upper limit is tested first, so with crossed limits a value above out_high gets out_high, any other out_low
        function longint clamp_to_limits(longint v, output bit hit);
            hit = 1'b0;
            if (v > longint'(out_high)) begin
                hit = 1'b1;
                return longint'(out_high);
            end
            if (v < longint'(out_low)) begin
                hit = 1'b1;
                return longint'(out_low);
            end
            return v;
        endfunction

        // Accepted input beat: advance the integrator and queue the result
        function void predict_pwm(logic [CMD_W-1:0] cmd, logic signed [RPM_W-1:0] meas);
            longint      tgt, err, mag, step, acc, pi, sum;
            bit          hit, ignored;
            t_pwm_result res;
            tgt = longint'(cmd) * longint'(speed_gain);
            if (tgt > TARGET_TOP) tgt = TARGET_TOP;
            err  = tgt - longint'(meas);
            step = (err * longint'(step_time)) >>> 16;
            mag  = (err < 0) ? -err : err;
            // deadband wipes the integral
            if (mag < longint'(deadband))
                acc = 0;
            else
                acc = sat_integ(longint'(integ_acc) + step);
            pi = (longint'(prop_gain) * err + longint'(integ_gain) * acc) >>> 8;
            pi = clamp_to_limits(pi, hit);
            // anti-windup: take the step back, even after a deadband clear
            if (hit) acc = sat_integ(acc - step);
            integ_acc = acc[ACC_W-1:0];
            sum = clamp_to_limits(longint'(cmd) * 256 + pi, ignored);
            res.correction = pi[LIM_W-1:0];
            res.final_pwm  = sum[PWM_W+7:8];
            res.target_rpm = tgt[TGT_W-1:0];
            res.clamped    = hit;
            pending_pwm_q.push_back(res);
        endfunction

        // Accepted output beat: compare with the oldest expectation
        function void check_pwm_beat(t_pwm_result got);
            t_pwm_result want;
            beats_checked++;
            if (pending_pwm_q.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("[%0t] unexpected beat: corr=%0d pwm=%0d tgt=%0d clamp=%0b",
                             $realtime, got.correction, got.final_pwm, got.target_rpm,
                             got.clamped);
                mismatches++;
                return;
            end
            want = pending_pwm_q.pop_front();
            if (want.correction != got.correction || want.final_pwm != got.final_pwm ||
                want.target_rpm != got.target_rpm || want.clamped != got.clamped) begin
                if (mismatches < MAX_REPORTS)
                    $display(
                        "[%0t] beat %0d exp/act: corr %0d/%0d pwm %0d/%0d tgt %0d/%0d hit %0b/%0b",
                        $realtime, beats_checked, want.correction, got.correction,
                        want.final_pwm, got.final_pwm, want.target_rpm, got.target_rpm,
                        want.clamped, got.clamped);
                mismatches++;
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DAT_W-1:0]    i_cfg_wdata;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic [CMD_W-1:0]        i_command_pct;
    logic signed [RPM_W-1:0] i_measured_rpm;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic [LIM_W-1:0]        o_correction;
    logic [PWM_W-1:0]        o_final_pwm;
    logic [TGT_W-1:0]        o_target_rpm;
    logic                    o_clamped;

    t_speed_loop_scoreboard loop_sb = new();
    int send_idle_pct  = 0;
    int out_stall_pct  = 0;
    int samples_sent   = 0;
    int settings_used  = 0;

    pi_speed_loop_antiwindup u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command_pct  (i_command_pct),
        .i_measured_rpm (i_measured_rpm),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_correction   (o_correction),
        .o_final_pwm    (o_final_pwm),
        .o_target_rpm   (o_target_rpm),
        .o_clamped      (o_clamped)
    );

    always #6 i_clk = ~i_clk;

    // Random backpressure on the output side
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    // Output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            loop_sb.check_pwm_beat('{o_correction, o_final_pwm, o_target_rpm, o_clamped});
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Timeout with %0d beats still pending", loop_sb.pending_pwm_q.size());
        $display("Simulation FAILED");
        $finish;
    end

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  out_stall_pct = 0;  end
            1: begin send_idle_pct = 81; out_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  out_stall_pct = 81; end
            default: begin send_idle_pct = 23; out_stall_pct = 23; end
        endcase
    endtask

    // Drive one input beat, with an optional random gap ahead of it
    task automatic send_sample(input logic [CMD_W-1:0] cmd, input logic signed [RPM_W-1:0] meas);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_command_pct  <= cmd;
        i_measured_rpm <= meas;
        do @(posedge i_clk); while (o_in_stall);
        loop_sb.predict_pwm(cmd, meas);
        samples_sent++;
    endtask

    // Let every pending beat come out, then give the pipeline time to empty
    task automatic settle();
        i_in_valid <= 1'b0;
        while (loop_sb.pending_pwm_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        loop_sb.write_reg(idx, data);
    endtask

    // Write a full setting; the spare top bit of the limit registers is random
    task automatic apply_settings(input t_loop_settings s);
        cfg_write(REG_SPEED_GAIN, s.speed_gain);
        cfg_write(REG_PROP_GAIN,  s.prop_gain);
        cfg_write(REG_INTEG_GAIN, s.integ_gain);
        cfg_write(REG_STEP_TIME,  s.step_time);
        cfg_write(REG_DEADBAND,   s.deadband);
        cfg_write(REG_OUT_LOW,    {1'($urandom()), s.out_low});
        cfg_write(REG_OUT_HIGH,   {1'($urandom()), s.out_high});
        cfg_write(REG_UNUSED,     16'($urandom()));
        i_cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    function automatic t_loop_settings default_settings();
        t_loop_settings s;
        s.speed_gain = RST_SPEED_GAIN;
        s.prop_gain  = RST_PROP_GAIN;
        s.integ_gain = RST_INTEG_GAIN;
        s.step_time  = RST_STEP_TIME;
        s.deadband   = RST_DEADBAND;
        s.out_low    = RST_OUT_LOW;
        s.out_high   = RST_OUT_HIGH;
        return s;
    endfunction

    // Random samples: mostly near the target, some near the deadband edge,
    // some anywhere; the windup mode pushes a large positive error on most beats
    task automatic run_random_phase(input int n_items, input bit windup);
        logic [CMD_W-1:0]        cmd;
        logic signed [RPM_W-1:0] meas;
        longint                  tgt, v;
        int                      spread, db;
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 4) == 0)
                cmd = CMD_W'($urandom_range(0, 127));
            else
                cmd = CMD_W'($urandom_range(0, 100));
            if (windup && $urandom_range(0, 99) < 85) begin
                cmd  = CMD_W'($urandom_range(100, 127));
                meas = 24'sh800000 + RPM_W'($urandom_range(0, 4194303));
            end else begin
                tgt = longint'(cmd) * longint'(loop_sb.speed_gain);
                if (tgt > TARGET_TOP) tgt = TARGET_TOP;
                db = (loop_sb.deadband > 1000) ? 1000 : int'(loop_sb.deadband);
                case ($urandom_range(0, 9))
                    0, 1: v = longint'($signed(RPM_W'($urandom())));
                    2, 3: v = tgt + longint'($urandom_range(0, 2 * db + 4)) - (db + 2);
                    default: begin
                        spread = $urandom_range(0, 20000);
                        v = tgt + longint'($urandom_range(0, 2 * spread)) - spread;
                    end
                endcase
                if (v > RPM_TOP) v = RPM_TOP;
                if (v < RPM_BOTTOM) v = RPM_BOTTOM;
                meas = v[RPM_W-1:0];
            end
            send_sample(cmd, meas);
        end
    endtask

    // Main sequence
    initial begin
        t_loop_settings s;
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_wdata    = '0;
        i_in_valid     = 1'b0;
        i_command_pct  = '0;
        i_measured_rpm = '0;
        i_out_stall    = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats on the reset settings
        set_idling(0);
        send_sample(7'd0,   24'sd0);           // zero error, deadband clear
        send_sample(7'd100, 24'sd0);           // large error, upper clamp
        send_sample(7'd0,   24'sh7FFFFF);      // fastest speed, lower clamp
        send_sample(7'd127, 24'sh800000);      // command above 100, slowest speed
        send_sample(7'd50,  24'sd32000);       // exactly on target
        send_sample(7'd50,  24'sd31998);       // inside the deadband
        send_sample(7'd50,  24'sd31997);       // on the deadband edge
        send_sample(7'd50,  24'sd32003);       // edge, negative error
        send_sample(7'd100, 24'sd63900);
        send_sample(7'd1,   24'sd600);

        // Zero step time: integral only cleared or kept
        settle();
        s = default_settings();
        s.step_time = 16'd0;
        apply_settings(s);
        send_sample(7'd80, 24'sd0);
        send_sample(7'd80, 24'sd50000);

        // Crossed limits: the upper limit wins above out_high, the lower one elsewhere
        settle();
        s = default_settings();
        s.out_low  = 15'd20000;
        s.out_high = 15'd5000;
        apply_settings(s);
        send_sample(7'd30, 24'sd0);
        send_sample(7'd30, 24'sd40000);
        send_sample(7'd30, 24'sd19200);

        // Clamp inside the deadband: step still taken back from the cleared integral
        settle();
        s = default_settings();
        s.deadband = 16'hFFFF;
        s.out_low  = 15'd1000;
        apply_settings(s);
        send_sample(7'd10, 24'sd6400);
        send_sample(7'd10, 24'sd6500);
        send_sample(7'd10, 24'sd6300);

        // Random phases, each with its own setting and one of four idling mixes
        for (int p = 0; p < 8; p++) begin
            settle();
            s = default_settings();
            case (p)
                1: begin   // pure integrator with no gain, drives it into saturation
                    s.speed_gain = 16'hFFFF; s.prop_gain = 16'd0; s.integ_gain = 16'd0;
                    s.step_time  = 16'hFFFF; s.deadband  = 16'd0;
                    s.out_low    = 15'd0;    s.out_high  = 15'h7FFF;
                end
                2: begin   // every register at its top but out_low, which is zero
                    s.speed_gain = 16'hFFFF; s.prop_gain = 16'hFFFF; s.integ_gain = 16'hFFFF;
                    s.step_time  = 16'hFFFF; s.deadband  = 16'hFFFF;
                    s.out_low    = 15'd0;    s.out_high  = 15'h7FFF;
                end
                3, 6: begin
                    s.speed_gain = GAIN_W'($urandom_range(0, 65535));
                    s.prop_gain  = GAIN_W'($urandom_range(0, 65535));
                    s.integ_gain = GAIN_W'($urandom_range(0, 65535));
                    s.step_time  = GAIN_W'($urandom_range(1, 65535));
                    s.deadband   = ($urandom_range(0, 3) == 0) ?
                                   GAIN_W'($urandom_range(0, 65535)) :
                                   GAIN_W'($urandom_range(0, 300));
                    s.out_low    = LIM_W'($urandom_range(0, 12800));
                    s.out_high   = (p == 6) ? LIM_W'($urandom_range(0, 32767)) :
                                   LIM_W'($urandom_range(s.out_low, 25600));
                end
                4: begin
                    s.speed_gain = 16'd256;  s.prop_gain = 16'd512; s.integ_gain = 16'd200;
                    s.step_time  = 16'd6554; s.deadband  = 16'd50;
                    s.out_low    = 15'd1000; s.out_high  = 15'd20000;
                end
                5: begin
                    s.out_low = 15'd20000; s.out_high = 15'd5000;
                end
                7: begin   // everything at its bottom but step_time, which is one
                    s.speed_gain = 16'd0; s.prop_gain = 16'd0; s.integ_gain = 16'd0;
                    s.step_time  = 16'd1; s.deadband  = 16'd0;
                    s.out_low    = 15'd0; s.out_high  = 15'd0;
                end
                default: ;
            endcase
            apply_settings(s);
            set_idling(p % 4);
            run_random_phase((p == 1) ? 200 : 57, p == 1);
        end

        settle();
        $display("Sent %0d speed samples over %0d register settings and four idling mixes;",
                 samples_sent, settings_used);
        $display("%0d output beats checked, %0d mismatches, %0d beats never arrived.",
                 loop_sb.beats_checked, loop_sb.mismatches, loop_sb.pending_pwm_q.size());
        if (loop_sb.mismatches == 0 && loop_sb.pending_pwm_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/pisl_pkg.sv
sv/pi_speed_loop_antiwindup.sv
tb/sv/tb_pi_speed_loop_antiwindup.sv
